[hdl/abdcs_pkg.sv]
package abdcs_pkg;

    localparam int DIGIT_SLOTS = 8;
    localparam int SLOT_BITS   = $clog2(DIGIT_SLOTS);

    // Scaling of the converter reading
    localparam logic [11:0] FULL_SCALE   = 12'd4095;
    localparam logic [9:0]  VIN_SPAN     = 10'd330;
    localparam logic [9:0]  VREAL_SPAN   = 10'd700;
    localparam logic [9:0]  VREAL_OFFSET = 10'd300;

    // Reciprocals for the decimal split, exact for values up to 1000
    localparam logic [7:0]  RECIP_10   = 8'd205;
    localparam int          SHIFT_10   = 11;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam int          SHIFT_100  = 12;
    localparam logic [9:0]  THOUSAND   = 10'd1000;

    // Register reset values
    localparam logic [15:0] REFRESH_LIMIT_RESET = 16'd480;
    localparam logic [11:0] LED_LOW_RESET       = 12'd1024;
    localparam logic [11:0] LED_HIGH_RESET      = 12'd3072;

    // Register indexes
    localparam logic [1:0] REG_REFRESH_LIMIT = 2'd0;
    localparam logic [1:0] REG_LED_LOW       = 2'd1;
    localparam logic [1:0] REG_LED_HIGH      = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_QUO   = 7'b0001000,
        ST_DIG   = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } state_t;

endpackage

[hdl/adc_to_bcd_digit_change_sender.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  adc_sample
// output    out        out_valid / out_stall tx_byte, byte_valid, last, red_level, green_level
// config    in         APB write/read       paddr, pwdata, prdata
//
// After acceptance a sample goes through the arithmetic states (multiply, divide, quotient,
// digit split), one read-compare-write pass over the eight digit slots of the previous-digit
// memory (one slot per cycle while the scan is not held), the flush and the idle state that
// takes the next sample. Reset clears the counter, the refresh flag and the slot valid bits,
// so every stored digit reads as zero until written. A stalled full output holds the scan at
// each new byte that meets a full hold register, and holds the flush.
module adc_to_bcd_digit_change_sender
    import abdcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             tx_byte,
    output logic                   byte_valid,
    output logic                   last,
    output logic                   red_level,
    output logic                   green_level,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int WIDE_BITS = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

    state_t state_reg, state_next;

    logic [15:0] refresh_limit_reg;
    logic [11:0] led_low_reg;
    logic [11:0] led_high_reg;

    logic [11:0] rest_reg, rest_next;
    logic        red_reg, red_next;
    logic        green_reg, green_next;
    logic [20:0] x_in_reg, x_in_next;
    logic [21:0] x_real_reg, x_real_next;
    logic [9:0]  v_in_reg, v_in_next;
    logic [9:0]  v_real_reg, v_real_next;
    logic [6:0]  q10_in_reg, q10_in_next;
    logic [6:0]  q10_real_reg, q10_real_next;
    logic [3:0]  q100_in_reg, q100_in_next;
    logic [3:0]  q100_real_reg, q100_real_next;
    logic        th_in_reg, th_in_next;
    logic        th_real_reg, th_real_next;
    logic [3:0]  cur_reg [DIGIT_SLOTS];
    logic [3:0]  cur_next [DIGIT_SLOTS];

    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic                 hold_full_reg, hold_full_next;
    logic [7:0]           hold_byte_reg, hold_byte_next;
    logic [15:0]          sent_count_reg, sent_count_next;
    logic                 refresh_pending_reg, refresh_pending_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_bv_reg, out_bv_next;
    logic       out_last_reg, out_last_next;
    logic       out_red_reg, out_red_next;
    logic       out_green_reg, out_green_next;

    // previous-digit memory
    logic [3:0]           mem [DIGIT_SLOTS];
    logic                 entry_valid_reg [DIGIT_SLOTS];
    logic [3:0]           rd_data_reg;
    logic                 rd_valid_reg;
    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_wr_addr;
    logic [3:0]           mem_wr_data;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;

    logic [WIDE_BITS-1:0] sample_wide;
    logic [11:0]          sample_clamped;
    logic [22:0]          sum_in;
    logic [22:0]          sum_real;
    logic [17:0]          prod10_in, prod10_real;
    logic [15:0]          prod100_in, prod100_real;
    logic [3:0]           prev_digit;
    logic [3:0]           cur_digit;
    logic                 emit;
    logic                 advance;
    logic                 out_free;
    logic                 cfg_write;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign tx_byte     = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign last        = out_last_reg;
    assign red_level   = out_red_reg;
    assign green_level = out_green_reg;
    assign pready      = 1'b1;

    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_REFRESH_LIMIT: prdata = {16'd0, refresh_limit_reg};
            REG_LED_LOW:       prdata = {20'd0, led_low_reg};
            REG_LED_HIGH:      prdata = {20'd0, led_high_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_limit_reg <= REFRESH_LIMIT_RESET;
            led_low_reg       <= LED_LOW_RESET;
            led_high_reg      <= LED_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_REFRESH_LIMIT: refresh_limit_reg <= pwdata[15:0];
                REG_LED_LOW:       led_low_reg       <= pwdata[11:0];
                REG_LED_HIGH:      led_high_reg      <= pwdata[11:0];
                default:           ;
            endcase
        end
    end

    assign sample_wide    = WIDE_BITS'(adc_sample);
    assign sample_clamped = (sample_wide > WIDE_BITS'(FULL_SCALE)) ? FULL_SCALE
                                                                   : sample_wide[11:0];

    // floor(x / 4095) as (x + (x >> 12) + 1) >> 12, exact below 2^24
    assign sum_in   = 23'(x_in_reg) + 23'(x_in_reg >> 12) + 23'd1;
    assign sum_real = 23'(x_real_reg) + 23'(x_real_reg >> 12) + 23'd1;

    assign prod10_in    = 18'(v_in_reg) * 18'(RECIP_10);
    assign prod10_real  = 18'(v_real_reg) * 18'(RECIP_10);
    assign prod100_in   = 16'(v_in_reg) * 16'(RECIP_100);
    assign prod100_real = 16'(v_real_reg) * 16'(RECIP_100);

    assign prev_digit = rd_valid_reg ? rd_data_reg : 4'd0;
    assign cur_digit  = cur_reg[slot_reg];
    assign emit       = (cur_digit != prev_digit) || refresh_pending_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign advance    = !(emit && hold_full_reg && !out_free);

    always_comb
    begin
        state_next           = state_reg;
        rest_next            = rest_reg;
        red_next             = red_reg;
        green_next           = green_reg;
        x_in_next            = x_in_reg;
        x_real_next          = x_real_reg;
        v_in_next            = v_in_reg;
        v_real_next          = v_real_reg;
        q10_in_next          = q10_in_reg;
        q10_real_next        = q10_real_reg;
        q100_in_next         = q100_in_reg;
        q100_real_next       = q100_real_reg;
        th_in_next           = th_in_reg;
        th_real_next         = th_real_reg;
        cur_next             = cur_reg;
        slot_next            = slot_reg;
        hold_full_next       = hold_full_reg;
        hold_byte_next       = hold_byte_reg;
        sent_count_next      = sent_count_reg;
        refresh_pending_next = refresh_pending_reg;
        out_byte_next        = out_byte_reg;
        out_bv_next          = out_bv_reg;
        out_last_next        = out_last_reg;
        out_red_next         = out_red_reg;
        out_green_next       = out_green_reg;
        out_valid_next       = out_valid_reg && out_stall;
        mem_we               = 1'b0;
        mem_wr_addr          = slot_reg;
        mem_wr_data          = cur_digit;
        rd_en                = 1'b0;
        rd_addr              = slot_reg + SLOT_BITS'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rest_next  = FULL_SCALE - sample_clamped;
                    red_next   = (sample_clamped <= led_low_reg);
                    green_next = (sample_clamped <= led_low_reg)
                                 || (sample_clamped <= led_high_reg);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                x_in_next   = 21'(rest_reg) * 21'(VIN_SPAN);
                x_real_next = 22'(rest_reg) * 22'(VREAL_SPAN);
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                v_in_next   = 10'(sum_in >> 12);
                v_real_next = 10'(sum_real >> 12) + VREAL_OFFSET;
                state_next  = ST_QUO;
            end
            ST_QUO:
            begin
                q10_in_next    = 7'(prod10_in >> SHIFT_10);
                q10_real_next  = 7'(prod10_real >> SHIFT_10);
                q100_in_next   = 4'(prod100_in >> SHIFT_100);
                q100_real_next = 4'(prod100_real >> SHIFT_100);
                th_in_next     = (v_in_reg >= THOUSAND);
                th_real_next   = (v_real_reg >= THOUSAND);
                state_next     = ST_DIG;
            end
            ST_DIG:
            begin
                cur_next[0] = 4'(v_in_reg - 10'(q10_in_reg) * 10'd10);
                cur_next[1] = 4'(q10_in_reg - 7'(q100_in_reg) * 7'd10);
                cur_next[2] = th_in_reg ? 4'(q100_in_reg - 4'd10) : q100_in_reg;
                cur_next[3] = {3'd0, th_in_reg};
                cur_next[4] = 4'(v_real_reg - 10'(q10_real_reg) * 10'd10);
                cur_next[5] = 4'(q10_real_reg - 7'(q100_real_reg) * 7'd10);
                cur_next[6] = th_real_reg ? 4'(q100_real_reg - 4'd10) : q100_real_reg;
                cur_next[7] = {3'd0, th_real_reg};
                // fetch the first slot so its data is there when the scan starts
                rd_en       = 1'b1;
                rd_addr     = '0;
                slot_next   = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    mem_we = 1'b1;
                    if (emit)
                    begin
                        hold_byte_next = {4'(slot_reg), cur_digit};
                        hold_full_next = 1'b1;
                        if (sent_count_reg != 16'hFFFF)
                        begin
                            sent_count_next = sent_count_reg + 16'd1;
                        end
                        // the held byte is not the last one: pass it on
                        if (hold_full_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = hold_byte_reg;
                            out_bv_next    = 1'b1;
                            out_last_next  = 1'b0;
                            out_red_next   = red_reg;
                            out_green_next = green_reg;
                        end
                    end
                    if (slot_reg == SLOT_BITS'(DIGIT_SLOTS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        slot_next = slot_reg + SLOT_BITS'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hold_full_reg ? hold_byte_reg : 8'd0;
                    out_bv_next    = hold_full_reg;
                    out_last_next  = 1'b1;
                    out_red_next   = red_reg;
                    out_green_next = green_reg;
                    hold_full_next = 1'b0;
                    if (sent_count_reg >= refresh_limit_reg)
                    begin
                        sent_count_next      = 16'd0;
                        refresh_pending_next = 1'b1;
                    end
                    else
                    begin
                        refresh_pending_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            slot_reg            <= '0;
            hold_full_reg       <= 1'b0;
            sent_count_reg      <= 16'd0;
            refresh_pending_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
            rd_valid_reg        <= 1'b0;
            for (int i = 0; i < DIGIT_SLOTS; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg           <= state_next;
            slot_reg            <= slot_next;
            hold_full_reg       <= hold_full_next;
            sent_count_reg      <= sent_count_next;
            refresh_pending_reg <= refresh_pending_next;
            out_valid_reg       <= out_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
            if (mem_we)
            begin
                entry_valid_reg[mem_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg       <= rest_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        x_in_reg       <= x_in_next;
        x_real_reg     <= x_real_next;
        v_in_reg       <= v_in_next;
        v_real_reg     <= v_real_next;
        q10_in_reg     <= q10_in_next;
        q10_real_reg   <= q10_real_next;
        q100_in_reg    <= q100_in_next;
        q100_real_reg  <= q100_real_next;
        th_in_reg      <= th_in_next;
        th_real_reg    <= th_real_next;
        cur_reg        <= cur_next;
        hold_byte_reg  <= hold_byte_next;
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_last_reg   <= out_last_next;
        out_red_reg    <= out_red_next;
        out_green_reg  <= out_green_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sample accepted while previous one still in work");

    a_flush_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && out_free) |=> (out_valid && last))
        else $error("flush did not deliver the final item of the sample");

    a_empty_item_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> last)
        else $error("empty item not marked last");

    a_digit_is_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (tx_byte[3:0] <= 4'd9))
        else $error("digit value out of decimal range");
`endif

endmodule

[tb/tb_adc_to_bcd_digit_change_sender.sv]
`timescale 1ns / 1ps

module tb_adc_to_bcd_digit_change_sender;
    import abdcs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       byte_valid;
        logic       last;
        logic       red_level;
        logic       green_level;
    } digit_byte_t;

    class digit_change_scoreboard;
        logic [3:0]  stored_digits [8];
        logic [15:0] sent_count;
        logic        refresh_pending;
        logic [15:0] refresh_limit;
        logic [11:0] led_low;
        logic [11:0] led_high;
        int          errors;
        digit_byte_t expected_bytes [$];

        function new();
            foreach (stored_digits[i])
                stored_digits[i] = 4'd0;
            sent_count      = 16'd0;
            refresh_pending = 1'b0;
            refresh_limit   = REFRESH_LIMIT_RESET;
            led_low         = LED_LOW_RESET;
            led_high        = LED_HIGH_RESET;
            errors          = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_REFRESH_LIMIT: refresh_limit = value[15:0];
                REG_LED_LOW:       led_low       = value[11:0];
                REG_LED_HIGH:      led_high      = value[11:0];
                default: ;
            endcase
        endfunction

        // Work out the digit bytes one sample sends and advance the stored digits.
        function void note_sample(logic [11:0] s);
            int unsigned rest;
            int unsigned v_in;
            int unsigned v_real;
            int unsigned scale;
            logic [3:0]  digits [8];
            bit   [7:0]  send_mask;
            logic        red;
            logic        green;
            int          n;
            int          sent;
            int          k;
            digit_byte_t item;

            rest   = 4095 - s;
            v_in   = (330 * rest) / 4095;
            v_real = (700 * rest) / 4095 + 300;
            scale  = 1;
            for (k = 0; k < 4; k++)
            begin
                digits[k]     = 4'((v_in / scale) % 10);
                digits[k + 4] = 4'((v_real / scale) % 10);
                scale         = scale * 10;
            end

            // low compare wins when the thresholds are crossed over
            if (s <= led_low)
            begin
                red   = 1'b1;
                green = 1'b1;
            end
            else if (s <= led_high)
            begin
                red   = 1'b0;
                green = 1'b1;
            end
            else
            begin
                red   = 1'b0;
                green = 1'b0;
            end

            n = 0;
            for (k = 0; k < 8; k++)
            begin
                send_mask[k] = (digits[k] != stored_digits[k]) || refresh_pending;
                if (send_mask[k])
                    n++;
            end

            sent = 0;
            for (k = 0; k < 8; k++)
            begin
                if (send_mask[k])
                begin
                    sent++;
                    item.tx_byte     = {4'(k), digits[k]};
                    item.byte_valid  = 1'b1;
                    item.last        = (sent == n);
                    item.red_level   = red;
                    item.green_level = green;
                    expected_bytes.push_back(item);
                    if (sent_count != 16'hFFFF)
                        sent_count++;
                end
                stored_digits[k] = digits[k];
            end

            if (n == 0)
            begin
                item.tx_byte     = 8'h00;
                item.byte_valid  = 1'b0;
                item.last        = 1'b1;
                item.red_level   = red;
                item.green_level = green;
                expected_bytes.push_back(item);
            end

            if (sent_count >= refresh_limit)
            begin
                sent_count      = 16'd0;
                refresh_pending = 1'b1;
            end
            else
                refresh_pending = 1'b0;
        endfunction

        function void check_result(digit_byte_t got);
            digit_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: tx_byte=%h byte_valid=%b last=%b red=%b green=%b",
                             got.tx_byte, got.byte_valid, got.last, got.red_level,
                             got.green_level);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.tx_byte !== want.tx_byte || got.byte_valid !== want.byte_valid ||
                got.last !== want.last || got.red_level !== want.red_level ||
                got.green_level !== want.green_level)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h/%b/%b/%b/%b got %h/%b/%b/%b/%b %s",
                             want.tx_byte, want.byte_valid, want.last, want.red_level,
                             want.green_level, got.tx_byte, got.byte_valid, got.last,
                             got.red_level, got.green_level,
                             "(tx_byte/byte_valid/last/red/green)");
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] adc_sample = 12'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  tx_byte;
    logic        byte_valid;
    logic        last;
    logic        red_level;
    logic        green_level;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    digit_change_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          cycle_count = 0;
    logic [11:0] last_sample = 12'd0;

    adc_to_bcd_digit_change_sender dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .red_level   (red_level),
        .green_level (green_level),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[adc_to_bcd_digit_change_sender] ERROR");
            $finish;
        end
    end

    // Output side: check each accepted item, then pick the stall for the next cycle.
    initial
    begin
        int          hold_left;
        digit_byte_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {tx_byte, byte_valid, last, red_level, green_level};
                sb.check_result(got);
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task send_sample(input logic [11:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
        last_sample = s;
    endtask

    // Drop valid and wait until every predicted byte has come out.
    task wait_quiet();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task set_config(input logic [15:0] limit, input logic [11:0] low, input logic [11:0] high);
        wait_quiet();
        apb_write(REG_REFRESH_LIMIT, {16'd0, limit});
        apb_write(REG_LED_LOW, {20'd0, low});
        apb_write(REG_LED_HIGH, {20'd0, high});
    endtask

    task run_random_samples(input int count, input bit pause_midway);
        logic [11:0] s;
        int          t;
        int          step;
        int          i;
        s = last_sample;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: s = 12'($urandom_range(0, 4095));
                5, 6: ;   // repeat the last sample: no digit change
                7, 8:
                begin
                    step = $urandom_range(0, 8);
                    t    = int'(s) + step - 4;
                    if (t < 0)
                        t = 0;
                    if (t > 4095)
                        t = 4095;
                    s = 12'(t);
                end
                default:
                    case ($urandom_range(0, 3))
                        0: s = 12'd0;
                        1: s = 12'd4095;
                        2: s = sb.led_low;
                        default: s = sb.led_high;
                    endcase
            endcase
            send_sample(s);
            if (pause_midway && i == count / 2)
                wait_quiet();
        end
    endtask

    initial
    begin
        logic [11:0] opening [10];
        logic [11:0] low;
        opening = '{12'd4095, 12'd4095, 12'd0, 12'd0, 12'd1024,
                    12'd1025, 12'd3072, 12'd3073, 12'd4094, 12'd1};
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-scale ends, repeats with no byte to send, threshold edges
        foreach (opening[i])
            send_sample(opening[i]);

        // Limit of one: every sample that sends arms a refresh of all slots
        set_config(16'd1, LED_LOW_RESET, LED_HIGH_RESET);
        repeat (3) send_sample(12'd100);

        // Limit of zero: refresh on every sample
        set_config(16'd0, LED_LOW_RESET, LED_HIGH_RESET);
        repeat (2) send_sample(12'd200);

        // Crossed thresholds: low compare takes priority
        set_config(16'd480, 12'd3000, 12'd1000);
        send_sample(12'd500);
        send_sample(12'd2000);
        send_sample(12'd3500);
        send_sample(12'd3000);

        // Build up a count, then lower the limit below it
        set_config(16'hFFFF, LED_LOW_RESET, LED_HIGH_RESET);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        set_config(16'd5, LED_LOW_RESET, LED_HIGH_RESET);
        send_sample(12'd2048);
        send_sample(12'd2048);

        send_idle_pct = 12;
        recv_idle_pct = 84;
        set_config(16'($urandom_range(1, 40)), 12'd0, 12'd4095);
        run_random_samples(82, 1'b1);

        send_idle_pct = 84;
        recv_idle_pct = 12;
        set_config(16'hFFFF, 12'd4095, 12'd0);
        run_random_samples(82, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        low = 12'($urandom_range(0, 4095));
        set_config(16'($urandom_range(1, 200)), low, 12'($urandom_range(low, 4095)));
        // hold the output off while the input keeps offering samples
        hold_requests = hold_requests + 1;
        run_random_samples(82, 1'b1);

        wait_quiet();
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("[adc_to_bcd_digit_change_sender] OK");
        else
            $display("[adc_to_bcd_digit_change_sender] ERROR");
        $finish;
    end

endmodule
